FILE: hdl/atp_pkg.sv
package atp_pkg;

    // Internal fixed-point format: unsigned magnitudes with 30 fraction bits
    localparam int IFRAC = 30;
    // Ratio width: z <= 1.0, so one integer bit on top of the fraction
    localparam int ZW = IFRAC + 1;
    // Width of the signed angle sum before rounding (|angle| < 4.0)
    localparam int RW = 34;
    // Pipeline depth: two front stages, one divider stage per quotient bit,
    // four polynomial stages and two output stages
    localparam int LATENCY = ZW + 8;

    // Polynomial and angle constants, rounded to the internal format
    localparam logic [63:0] N1_Q64 =
        ((64'd97239411 << IFRAC) + 64'd50000000) / 64'd100000000;
    localparam logic [63:0] N2M_Q64 =
        ((64'd19194795 << IFRAC) + 64'd50000000) / 64'd100000000;
    localparam logic [63:0] PI_Q64 =
        ((64'd3141592654 << IFRAC) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] HPI_Q64 =
        ((64'd1570796327 << IFRAC) + 64'd500000000) / 64'd1000000000;

    localparam logic [IFRAC-1:0] N1_Q = N1_Q64[IFRAC-1:0];
    localparam logic [IFRAC-1:0] N2M_Q = N2M_Q64[IFRAC-1:0];
    localparam logic signed [RW-1:0] PI_R = PI_Q64[RW-1:0];
    localparam logic signed [RW-1:0] HPI_R = HPI_Q64[RW-1:0];

    // Angle offset applied to the polynomial term
    typedef enum logic [2:0] {
        BASE_ZERO,
        BASE_PI_POS,
        BASE_PI_NEG,
        BASE_HPI_POS,
        BASE_HPI_NEG
    } t_base;

    // Control that travels alongside the ratio through the pipeline
    typedef struct packed {
        t_base base;
        logic  flip;
        logic  use_term;
    } t_side;

endpackage

FILE: hdl/atp_prep.sv
module atp_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    output logic                          o_valid,
    output logic        [COORD_WIDTH-1:0] o_num,
    output logic        [COORD_WIDTH-1:0] o_den,
    output atp_pkg::t_side                o_side
);
    import atp_pkg::*;

    localparam int W = COORD_WIDTH;

    logic         r_s1_vld;
    logic [W-1:0] r_s1_ay;
    logic [W-1:0] r_s1_ax;
    logic         r_s1_yneg;
    logic         r_s1_xneg;
    logic         r_s1_xzero;
    logic         r_s1_yzero;

    logic [W-1:0] n_s1_ay;
    logic [W-1:0] n_s1_ax;

    logic         r_s2_vld;
    logic [W-1:0] r_s2_num;
    logic [W-1:0] r_s2_den;
    t_side        r_s2_side;

    logic         x_ge;
    logic [W-1:0] n_s2_num;
    logic [W-1:0] n_s2_den;
    t_side        n_s2_side;

    // Take magnitudes of both coordinates
    always_comb begin
        n_s1_ay = i_y[W-1] ? W'(-i_y) : W'(i_y);
        n_s1_ax = i_x[W-1] ? W'(-i_x) : W'(i_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
        end
        r_s1_ay    <= n_s1_ay;
        r_s1_ax    <= n_s1_ax;
        r_s1_yneg  <= i_y[W-1];
        r_s1_xneg  <= i_x[W-1];
        r_s1_xzero <= (i_x == '0);
        r_s1_yzero <= (i_y == '0);
    end

    // Pick the octant: smaller magnitude over larger, and the offset to add
    always_comb begin
        x_ge            = (r_s1_ax >= r_s1_ay);
        n_s2_num        = x_ge ? r_s1_ay : r_s1_ax;
        n_s2_den        = x_ge ? r_s1_ax : r_s1_ay;
        n_s2_side.flip  = r_s1_yneg ^ r_s1_xneg ^ !x_ge;
        if (r_s1_xzero) begin
            n_s2_side.use_term = 1'b0;
            if (r_s1_yzero) begin
                n_s2_side.base = BASE_ZERO;
            end else if (r_s1_yneg) begin
                n_s2_side.base = BASE_HPI_NEG;
            end else begin
                n_s2_side.base = BASE_HPI_POS;
            end
        end else if (x_ge) begin
            n_s2_side.use_term = 1'b1;
            if (!r_s1_xneg) begin
                n_s2_side.base = BASE_ZERO;
            end else if (r_s1_yneg) begin
                n_s2_side.base = BASE_PI_NEG;
            end else begin
                n_s2_side.base = BASE_PI_POS;
            end
        end else begin
            n_s2_side.use_term = 1'b1;
            n_s2_side.base     = r_s1_yneg ? BASE_HPI_NEG : BASE_HPI_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_num  <= n_s2_num;
        r_s2_den  <= n_s2_den;
        r_s2_side <= n_s2_side;
    end

    assign o_valid = r_s2_vld;
    assign o_num   = r_s2_num;
    assign o_den   = r_s2_den;
    assign o_side  = r_s2_side;

endmodule

FILE: hdl/atp_div.sv
module atp_div #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [COORD_WIDTH-1:0]   i_num,
    input  logic [COORD_WIDTH-1:0]   i_den,
    input  atp_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [atp_pkg::ZW-1:0]   o_z,
    output atp_pkg::t_side           o_side
);
    import atp_pkg::*;

    localparam int W = COORD_WIDTH;

    // One restoring step per stage; stage k settles quotient bit ZW-1-k
    logic [W-1:0]  r_rem  [ZW];
    logic [W-1:0]  r_den  [ZW];
    logic [ZW-1:0] r_q    [ZW];
    t_side         r_side [ZW];
    logic [ZW-1:0] r_vld;

    logic [W:0]    trial   [ZW];
    logic [W:0]    diff    [ZW];
    logic [W-1:0]  den_in  [ZW];
    logic [ZW-1:0] q_in    [ZW];
    t_side         side_in [ZW];
    logic [ZW-1:0] vld_in;
    logic [ZW-1:0] ge;
    logic [W-1:0]  n_rem   [ZW];
    logic [ZW-1:0] n_q     [ZW];

    // Route each stage's inputs; the first stage tests the integer bit unshifted
    always_comb begin
        trial[0]   = {1'b0, i_num};
        den_in[0]  = i_den;
        q_in[0]    = '0;
        side_in[0] = i_side;
        vld_in[0]  = i_valid;
        for (int k = 1; k < ZW; k++) begin
            trial[k]   = {r_rem[k-1], 1'b0};
            den_in[k]  = r_den[k-1];
            q_in[k]    = r_q[k-1];
            side_in[k] = r_side[k-1];
            vld_in[k]  = r_vld[k-1];
        end
    end

    // Compare and subtract in every stage
    always_comb begin
        for (int k = 0; k < ZW; k++) begin
            diff[k]  = trial[k] - {1'b0, den_in[k]};
            ge[k]    = (trial[k] >= {1'b0, den_in[k]});
            n_rem[k] = ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
            n_q[k]   = {q_in[k][ZW-2:0], ge[k]};
        end
    end

    // Advance all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= vld_in;
        end
        for (int k = 0; k < ZW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_den[k]  <= den_in[k];
            r_q[k]    <= n_q[k];
            r_side[k] <= side_in[k];
        end
    end

    assign o_valid = r_vld[ZW-1];
    assign o_z     = r_q[ZW-1];
    assign o_side  = r_side[ZW-1];

endmodule

FILE: hdl/atp_poly.sv
module atp_poly (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [atp_pkg::ZW-1:0] i_z,
    input  atp_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [atp_pkg::ZW-1:0] o_t,
    output atp_pkg::t_side         o_side
);
    import atp_pkg::*;

    localparam int SQW = 2 * ZW;
    localparam int PW  = IFRAC + ZW;

    logic            r_s1_vld;
    logic [SQW-1:0]  r_s1_sq;
    logic [ZW-1:0]   r_s1_z;
    t_side           r_s1_side;

    logic            r_s2_vld;
    logic [PW-1:0]   r_s2_n2;
    logic [ZW-1:0]   r_s2_z;
    t_side           r_s2_side;

    logic            r_s3_vld;
    logic [IFRAC-1:0] r_s3_p;
    logic [ZW-1:0]   r_s3_z;
    t_side           r_s3_side;

    logic            r_s4_vld;
    logic [PW-1:0]   r_s4_t;
    t_side           r_s4_side;

    logic [SQW-1:0]  n_s1_sq;
    logic [PW-1:0]   n_s2_n2;
    logic [IFRAC-1:0] n_s3_p;
    logic [PW-1:0]   n_s4_t;

    // z^2, then n2 * z^2, then p = n1 - n2 * z^2, then p * z
    always_comb begin
        n_s1_sq = SQW'(i_z) * SQW'(i_z);
        n_s2_n2 = PW'(N2M_Q) * PW'(r_s1_sq[2*IFRAC:IFRAC]);
        n_s3_p  = N1_Q - r_s2_n2[2*IFRAC-1:IFRAC];
        n_s4_t  = PW'(r_s3_p) * PW'(r_s3_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
        r_s1_sq   <= n_s1_sq;
        r_s1_z    <= i_z;
        r_s1_side <= i_side;
        r_s2_n2   <= n_s2_n2;
        r_s2_z    <= r_s1_z;
        r_s2_side <= r_s1_side;
        r_s3_p    <= n_s3_p;
        r_s3_z    <= r_s2_z;
        r_s3_side <= r_s2_side;
        r_s4_t    <= n_s4_t;
        r_s4_side <= r_s3_side;
    end

    assign o_valid = r_s4_vld;
    assign o_t     = r_s4_t[2*IFRAC:IFRAC];
    assign o_side  = r_s4_side;

endmodule

FILE: hdl/atp_out.sv
module atp_out #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [atp_pkg::ZW-1:0]       i_t,
    input  atp_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [ANGLE_FRAC_BITS+2:0]   o_angle
);
    import atp_pkg::*;

    localparam int AW     = ANGLE_FRAC_BITS + 3;
    localparam int RSHIFT = IFRAC - ANGLE_FRAC_BITS;
    localparam logic signed [RW:0] HALF = (RW+1)'(64'd1 << (RSHIFT - 1));
    localparam logic signed [RW:0] AMAX = (RW+1)'((64'd1 << (AW - 1)) - 64'd1);
    localparam logic signed [RW:0] AMIN = -AMAX - (RW+1)'(1);

    logic                 r_s1_vld;
    logic signed [RW-1:0] r_s1_r;
    logic                 r_s2_vld;
    logic [AW-1:0]        r_s2_angle;

    logic signed [RW-1:0] base;
    logic signed [RW-1:0] term;
    logic signed [RW-1:0] n_s1_r;
    logic signed [RW:0]   sum;
    logic signed [RW:0]   shifted;
    logic [AW-1:0]        n_s2_angle;

    // Add the offset and the signed polynomial term
    always_comb begin
        case (i_side.base)
            BASE_ZERO:    base = '0;
            BASE_PI_POS:  base = PI_R;
            BASE_PI_NEG:  base = -PI_R;
            BASE_HPI_POS: base = HPI_R;
            BASE_HPI_NEG: base = -HPI_R;
            default:      base = '0;
        endcase
        term   = i_side.use_term ? signed'(RW'(i_t)) : '0;
        n_s1_r = i_side.flip ? base - term : base + term;
    end

    // Round half up to the output grid and clamp to the field range
    always_comb begin
        sum     = {r_s1_r[RW-1], r_s1_r} + HALF;
        shifted = sum >>> RSHIFT;
        if (shifted > AMAX) begin
            n_s2_angle = AMAX[AW-1:0];
        end else if (shifted < AMIN) begin
            n_s2_angle = AMIN[AW-1:0];
        end else begin
            n_s2_angle = shifted[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_r     <= n_s1_r;
        r_s2_angle <= n_s2_angle;
    end

    assign o_valid = r_s2_vld;
    assign o_angle = r_s2_angle;

endmodule

FILE: hdl/atan2_poly_approx.sv
// Four-quadrant arctangent, one coordinate pair per transfer.
// Pipeline: 2 front stages, 31 divider
// stages at one quotient bit each, 4 polynomial stages, 2 output stages.
// Throughput: one transfer every cycle; busy stays low.
// Reset (synchronous, active low) clears all valid bits; the receiver cannot stall.
module atan2_poly_approx #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_y_coord,
    input  logic signed [COORD_WIDTH-1:0]   i_x_coord,
    output logic                            o_valid,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_angle
);
    import atp_pkg::*;

    logic                   accept;
    logic                   prep_vld;
    logic [COORD_WIDTH-1:0] prep_num;
    logic [COORD_WIDTH-1:0] prep_den;
    t_side                  prep_side;
    logic                   div_vld;
    logic [ZW-1:0]          div_z;
    t_side                  div_side;
    logic                   poly_vld;
    logic [ZW-1:0]          poly_t;
    t_side                  poly_side;
    logic [ANGLE_FRAC_BITS+2:0] angle;

    // The pipeline never holds off a transfer
    assign busy   = 1'b0;
    assign accept = start && !busy;

    atp_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_y     (i_y_coord),
        .i_x     (i_x_coord),
        .o_valid (prep_vld),
        .o_num   (prep_num),
        .o_den   (prep_den),
        .o_side  (prep_side)
    );

    atp_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_vld),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .i_side  (prep_side),
        .o_valid (div_vld),
        .o_z     (div_z),
        .o_side  (div_side)
    );

    atp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_vld),
        .i_z     (div_z),
        .i_side  (div_side),
        .o_valid (poly_vld),
        .o_t     (poly_t),
        .o_side  (poly_side)
    );

    atp_out #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (poly_vld),
        .i_t     (poly_t),
        .i_side  (poly_side),
        .o_valid (o_valid),
        .o_angle (angle)
    );

    assign o_angle = signed'(angle);

endmodule

FILE: hdl/atp_chk.sv
module atp_chk #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [COORD_WIDTH-1:0]     i_y_coord,
    input logic signed [COORD_WIDTH-1:0]     i_x_coord,
    input logic                              o_valid,
    input logic signed [ANGLE_FRAC_BITS+2:0] o_angle
);
    import atp_pkg::*;

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset cycle");

    // Every transfer yields exactly one result after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("transfer without result");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without transfer");

    // The origin maps to a zero angle
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_x_coord, LATENCY) == '0 && $past(i_y_coord, LATENCY) == '0)
        |-> o_angle == '0)
        else $error("nonzero angle at origin");

    // No positive y ever gives a negative angle
    a_upper_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_y_coord, LATENCY) > 0) |-> !o_angle[ANGLE_FRAC_BITS+2])
        else $error("negative angle for positive y");

endmodule

bind atan2_poly_approx atp_chk #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atp_chk (.*);

FILE: tb/sv/atan2_poly_approx_tb.sv
module atan2_poly_approx_tb;

    localparam int CW          = 16;
    localparam int AFB         = 13;
    localparam int AW          = AFB + 3;
    localparam int FRAC_Q      = 30;
    localparam int RND_SHIFT   = FRAC_Q - AFB;
    localparam int PIPE_DEPTH  = 39;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PAIRS  = 1530;
    localparam int N_DIRECTED  = 24;

    // Q.30 constants of the arctangent polynomial and the quadrant offsets
    localparam bit [63:0] N1_K  = ((64'd97239411 << FRAC_Q) + 64'd50000000) / 64'd100000000;
    localparam bit [63:0] N2_K  = ((64'd19194795 << FRAC_Q) + 64'd50000000) / 64'd100000000;
    localparam bit [63:0] PI_K  =
        ((64'd3141592654 << FRAC_Q) + 64'd500000000) / 64'd1000000000;
    localparam bit [63:0] HPI_K =
        ((64'd1570796327 << FRAC_Q) + 64'd500000000) / 64'd1000000000;

    typedef struct packed {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
        logic                 known;
        logic signed [AW-1:0] angle;
    } t_coord_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic signed [CW-1:0]  i_y_coord = '0;
    logic signed [CW-1:0]  i_x_coord = '0;
    logic                  busy;
    logic                  o_valid;
    logic signed [AW-1:0]  o_angle;

    logic signed [AW-1:0]  pending_angles [$];
    t_coord_row            directed [N_DIRECTED];
    int                    idle_pct = 10;
    int                    bad_results = 0;
    int                    cycle_count = 0;

    atan2_poly_approx #(
        .COORD_WIDTH    (CW),
        .ANGLE_FRAC_BITS(AFB)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_y_coord(i_y_coord),
        .i_x_coord(i_x_coord),
        .o_valid  (o_valid),
        .o_angle  (o_angle)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Signed first-octant term z*(n1 - n2*z^2) for z = num/den, Q.30
    function automatic longint octant_term(longint num, longint den);
        bit [63:0] mag_n;
        bit [63:0] mag_d;
        bit [63:0] z;
        bit [63:0] z2;
        bit [63:0] p;
        bit [63:0] t;
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        if (mag_d == 0)
            return 0;
        z = (mag_n << FRAC_Q) / mag_d;
        if (z > (64'd1 << FRAC_Q))
            z = 64'd1 << FRAC_Q;
        z2 = (z * z) >> FRAC_Q;
        p  = N1_K - ((N2_K * z2) >> FRAC_Q);
        t  = (p * z) >> FRAC_Q;
        return ((num < 0) != (den < 0)) ? -longint'(t) : longint'(t);
    endfunction

    // Four-quadrant angle in Q3.13, rounded half up and saturated
    function automatic logic signed [AW-1:0] atan2_q13(logic signed [CW-1:0] y,
                                                       logic signed [CW-1:0] x);
        longint ys;
        longint xs;
        longint ay;
        longint ax;
        longint r;
        longint a;
        ys = longint'(y);
        xs = longint'(x);
        ay = (ys < 0) ? -ys : ys;
        ax = (xs < 0) ? -xs : xs;
        if (xs != 0) begin
            if (ax >= ay) begin
                r = octant_term(ys, xs);
                if (xs < 0)
                    r = r + ((ys < 0) ? -longint'(PI_K) : longint'(PI_K));
            end else begin
                r = ((ys < 0) ? -longint'(HPI_K) : longint'(HPI_K)) - octant_term(xs, ys);
            end
        end else if (ys > 0) begin
            r = HPI_K;
        end else if (ys < 0) begin
            r = -longint'(HPI_K);
        end else begin
            r = 0;
        end
        a = (r + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
        if (a > (longint'(1) << (AW - 1)) - 1)
            a = (longint'(1) << (AW - 1)) - 1;
        if (a < -(longint'(1) << (AW - 1)))
            a = -(longint'(1) << (AW - 1));
        return a[AW-1:0];
    endfunction

    // Present one coordinate pair, hold it until the transfer, queue its angle
    task automatic transfer_pair(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x,
                                 input logic known, input logic signed [AW-1:0] angle);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_y_coord <= y;
        i_x_coord <= x;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_angles.push_back(known ? angle : atan2_q13(y, x));
    endtask

    // Drop start and hold off until every queued angle has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0)
            @(posedge i_clk);
    endtask

    // Check each result against the oldest queued angle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_angles.size() == 0) begin
                $error("angle result with nothing pending: got %0d", o_angle);
                bad_results = bad_results + 1;
            end else begin
                if (o_angle !== pending_angles[0]) begin
                    $error("angle mismatch: expected %0d, actual %0d",
                           pending_angles[0], o_angle);
                    bad_results = bad_results + 1;
                end
                void'(pending_angles.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int                   kind;
        int                   base;
        int                   pick;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] edge_vals [6];

        edge_vals = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

        // Axes and origin are read off directly; the rest goes through the predictor
        directed = '{
            '{16'sd0,      16'sd0,      1'b1, 16'sd0},
            '{16'sd1,      16'sd0,      1'b1, 16'sd12868},
            '{-16'sd1,     16'sd0,      1'b1, -16'sd12868},
            '{16'sd32767,  16'sd0,      1'b1, 16'sd12868},
            '{-16'sd32768, 16'sd0,      1'b1, -16'sd12868},
            '{16'sd0,      16'sd1,      1'b1, 16'sd0},
            '{16'sd0,      16'sd32767,  1'b1, 16'sd0},
            '{16'sd0,      -16'sd1,     1'b1, 16'sd25736},
            '{16'sd0,      -16'sd32768, 1'b1, 16'sd25736},
            '{16'sd1,      16'sd1,      1'b0, 16'sd0},
            '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
            '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
            '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
            '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
            '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
            '{-16'sd32768, -16'sd32767, 1'b0, 16'sd0},
            '{16'sd1,      -16'sd32768, 1'b0, 16'sd0},
            '{-16'sd1,     -16'sd32768, 1'b0, 16'sd0},
            '{16'sd32767,  16'sd1,      1'b0, 16'sd0},
            '{-16'sd32768, -16'sd1,     1'b0, 16'sd0},
            '{16'sd1000,   -16'sd3000,  1'b0, 16'sd0},
            '{-16'sd3000,  16'sd1000,   1'b0, 16'sd0},
            '{16'sd12345,  -16'sd12345, 1'b0, 16'sd0},
            '{-16'sd1,     16'sd32767,  1'b0, 16'sd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: axes, diagonals, extremes, every quadrant
        idle_pct = 10;
        for (int i = 0; i < N_DIRECTED; i++)
            transfer_pair(directed[i].y, directed[i].x, directed[i].known, directed[i].angle);
        drain_results();

        // Random pairs in three phases: light idling, heavy idling, none
        for (int n = 0; n < RAND_PAIRS; n++) begin
            if (n == RAND_PAIRS / 3) begin
                drain_results();
                idle_pct = 80;
            end else if (n == 2 * RAND_PAIRS / 3) begin
                drain_results();
                idle_pct = 0;
            end
            kind = $urandom_range(0, 9);
            ry   = CW'($urandom);
            rx   = CW'($urandom);
            case (kind)
                5: begin
                    // small magnitudes, coarse ratios
                    ry = CW'($signed($urandom_range(0, 16)) - 8);
                    rx = CW'($signed($urandom_range(0, 16)) - 8);
                end
                6: begin
                    // near the diagonals, where the octant choice flips
                    base = $signed($urandom_range(0, 65535)) - 32768;
                    pick = $signed($urandom_range(0, 4)) - 2;
                    rx   = CW'(base);
                    ry   = CW'(($urandom_range(0, 1) ? base : -base) + pick);
                end
                7: begin
                    // one component on an axis
                    if ($urandom_range(0, 1))
                        rx = '0;
                    else
                        ry = '0;
                end
                8: begin
                    ry = edge_vals[3'($urandom_range(0, 5))];
                    rx = edge_vals[3'($urandom_range(0, 5))];
                end
                9: begin
                    // one large, one small component
                    ry = CW'($signed($urandom_range(0, 64)) - 32);
                    if ($urandom_range(0, 1)) begin
                        ry = rx;
                        rx = CW'($signed($urandom_range(0, 64)) - 32);
                    end
                end
                default: ;
            endcase
            transfer_pair(ry, rx, 1'b0, '0);
        end

        // Flush the pipeline, then keep clocking idle to catch stray results
        drain_results();
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);

        if (bad_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/atp_pkg.sv
hdl/atp_prep.sv
hdl/atp_div.sv
hdl/atp_poly.sv
hdl/atp_out.sv
hdl/atan2_poly_approx.sv
hdl/atp_chk.sv
tb/sv/atan2_poly_approx_tb.sv
